@@ design/ipt_pkg.sv @@
// Package for the IDE PIO timing calculator: widths, codes, the mode timing
// table and the shared payload types.
// No dependencies; every design file refers to it by scoped names.
package ipt_pkg;

  // Field and datapath widths.
  localparam int ModeW    = 3;
  localparam int BasicW   = 8;
  localparam int AdvW     = 3;
  localparam int TimeW    = 16;
  localparam int PeriodW  = 8;
  localparam int ChipW    = 2;
  localparam int CodeW    = 8;
  localparam int CfgDataW = 8;
  localparam int CfgIdxW  = 1;

  // Numerator of a ceiling division: a 16-bit time plus period - 1.
  localparam int NumW     = TimeW + 1;
  localparam int NumIdxW  = $clog2(NumW);
  // The running remainder stays below the period.
  localparam int RemW     = PeriodW;

  // Default number of quotient bits resolved in each divider stage.
  localparam int DivBitsPerStage = 3;

  // Divider lanes, one per timing.
  localparam int NumLanes  = 3;
  localparam int LaneCycle = 0;
  localparam int LaneAddr  = 1;
  localparam int LaneData  = 2;

  typedef logic [ModeW-1:0] mode_t;
  typedef logic [NumLanes-1:0][NumW-1:0] lanes_t;

  typedef struct packed {
    logic [TimeW-1:0] cycle_ns;
    logic [TimeW-1:0] addr_ns;
    logic [TimeW-1:0] data_ns;
  } timing_t;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgClockPeriod = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgChipVersion = 1'd1;

  // Configuration reset values.
  localparam logic [PeriodW-1:0] PeriodReset = 8'd30;
  localparam logic [ChipW-1:0]   ChipReset   = 2'd1;

  // Mode codes.
  localparam mode_t Mode3   = 3'd3;
  localparam mode_t Mode4   = 3'd4;
  localparam mode_t Mode5   = 3'd5;
  localparam mode_t MaxMode = Mode5;

  // Active time codes.
  localparam logic [CodeW-1:0] ActiveUpTo2 = 8'h40;
  localparam logic [CodeW-1:0] Active3     = 8'h80;
  localparam logic [CodeW-1:0] Active4     = 8'h00;
  localparam logic [CodeW-1:0] ActiveLong  = 8'hc0;

  // Clamps on the setup counts.
  localparam int MinClocks = 2;
  localparam int AddrLimit = 15;
  localparam int DataLimit = 17;
  localparam int NibLimit  = 15;

  // Nanosecond timings of each PIO mode: cycle, address setup, data setup.
  function automatic timing_t mode_timing(mode_t m);
    timing_t t;
    case (m)
      3'd0:    t = '{cycle_ns: 16'd70, addr_ns: 16'd165, data_ns: 16'd600};
      3'd1:    t = '{cycle_ns: 16'd50, addr_ns: 16'd125, data_ns: 16'd383};
      3'd2:    t = '{cycle_ns: 16'd30, addr_ns: 16'd100, data_ns: 16'd240};
      3'd3:    t = '{cycle_ns: 16'd30, addr_ns: 16'd80,  data_ns: 16'd180};
      3'd4:    t = '{cycle_ns: 16'd25, addr_ns: 16'd70,  data_ns: 16'd125};
      default: t = '{cycle_ns: 16'd20, addr_ns: 16'd50,  data_ns: 16'd100};
    endcase
    return t;
  endfunction

endpackage

@@ design/ipt_select.sv @@
// First pipeline stage: picks the PIO mode and the three nanosecond timings,
// and forms the ceiling-division numerators. Depends on ipt_pkg.
module ipt_select (
  input  logic                         clk,
  input  logic                         stage_en,
  input  logic [ipt_pkg::PeriodW-1:0]  period,
  input  logic                         known_valid,
  input  logic [ipt_pkg::ModeW-1:0]    known_mode,
  input  logic [ipt_pkg::BasicW-1:0]   basic_mode,
  input  logic                         extended_valid,
  input  logic                         iordy_capable,
  input  logic [ipt_pkg::AdvW-1:0]     advanced_modes,
  input  logic [ipt_pkg::TimeW-1:0]    iordy_cycle_ns,
  input  logic [ipt_pkg::TimeW-1:0]    plain_cycle_ns,
  output ipt_pkg::lanes_t              num_out,
  output ipt_pkg::mode_t               mode_out
);

  ipt_pkg::lanes_t num_r, num_nxt;
  ipt_pkg::mode_t  mode_r, mode_nxt;

  // Mode and timing selection.
  always_comb begin
    ipt_pkg::timing_t          base_t;
    ipt_pkg::timing_t          adv_t;
    logic [ipt_pkg::TimeW-1:0] cyc;
    logic [ipt_pkg::TimeW-1:0] adr;
    logic [ipt_pkg::TimeW-1:0] dat;
    logic [ipt_pkg::NumW-1:0]  bias;

    if (known_valid) begin
      mode_nxt = (known_mode > ipt_pkg::MaxMode) ? ipt_pkg::MaxMode : known_mode;
    end else if (basic_mode > ipt_pkg::BasicW'(ipt_pkg::MaxMode)) begin
      mode_nxt = ipt_pkg::MaxMode;
    end else begin
      mode_nxt = basic_mode[ipt_pkg::ModeW-1:0];
    end
    base_t = ipt_pkg::mode_timing(mode_nxt);
    cyc = base_t.cycle_ns;
    adr = base_t.addr_ns;
    dat = base_t.data_ns;

    if (!known_valid && extended_valid) begin
      if (iordy_capable && (advanced_modes != '0)) begin
        if (advanced_modes[2]) begin
          mode_nxt = ipt_pkg::Mode5;
        end else if (advanced_modes[1]) begin
          mode_nxt = ipt_pkg::Mode4;
        end else begin
          mode_nxt = ipt_pkg::Mode3;
        end
        dat = iordy_cycle_ns;
      end else begin
        dat = plain_cycle_ns;
      end
    end
    adv_t = ipt_pkg::mode_timing(mode_nxt);
    if (!known_valid && extended_valid) begin
      cyc = adv_t.cycle_ns;
      adr = adv_t.addr_ns;
      if (dat == '0) begin
        dat = adv_t.data_ns;
      end
    end

    // Ceiling division numerators: time + period - 1 (period is never zero).
    bias = ipt_pkg::NumW'(period) - ipt_pkg::NumW'(1);
    num_nxt[ipt_pkg::LaneCycle] = ipt_pkg::NumW'(cyc) + bias;
    num_nxt[ipt_pkg::LaneAddr]  = ipt_pkg::NumW'(adr) + bias;
    num_nxt[ipt_pkg::LaneData]  = ipt_pkg::NumW'(dat) + bias;
  end

  // Stage register.
  always_ff @(posedge clk) begin
    if (stage_en) begin
      num_r  <= num_nxt;
      mode_r <= mode_nxt;
    end
  end

  assign num_out  = num_r;
  assign mode_out = mode_r;

endmodule

@@ design/ipt_divider.sv @@
// Pipelined restoring divider, three lanes sharing one divisor, a few quotient
// bits per stage. Depends on ipt_pkg.
module ipt_divider #(
  parameter int BITS_PER_STAGE = ipt_pkg::DivBitsPerStage
) (
  input  logic                                  clk,
  input  logic [(ipt_pkg::NumW + BITS_PER_STAGE - 1) / BITS_PER_STAGE - 1:0] stage_en,
  input  logic [ipt_pkg::PeriodW-1:0]           period,
  input  ipt_pkg::lanes_t                       num_in,
  input  ipt_pkg::mode_t                        mode_in,
  output ipt_pkg::lanes_t                       quo_out,
  output ipt_pkg::mode_t                        mode_out
);

  localparam int Stages = (ipt_pkg::NumW + BITS_PER_STAGE - 1) / BITS_PER_STAGE;

  typedef logic [ipt_pkg::NumLanes-1:0][ipt_pkg::RemW-1:0] rems_t;

  // Each lane word holds quotient bits above the current position and the
  // unconsumed numerator bits below it.
  ipt_pkg::lanes_t work_r [Stages];
  rems_t           rem_r  [Stages];
  ipt_pkg::mode_t  mode_r [Stages];

  for (genvar s = 0; s < Stages; s++) begin : g_stage
    localparam int TopBit = ipt_pkg::NumW - 1 - s * BITS_PER_STAGE;

    ipt_pkg::lanes_t work_in, work_nxt;
    rems_t           rem_in, rem_nxt;
    ipt_pkg::mode_t  mode_stage_in;

    if (s == 0) begin : g_first
      assign work_in       = num_in;
      assign rem_in        = '0;
      assign mode_stage_in = mode_in;
    end else begin : g_next
      assign work_in       = work_r[s-1];
      assign rem_in        = rem_r[s-1];
      assign mode_stage_in = mode_r[s-1];
    end

    // One shift-compare-subtract step per quotient bit.
    always_comb begin
      logic [ipt_pkg::RemW:0] trial;
      int                     bit_idx;
      work_nxt = work_in;
      rem_nxt  = rem_in;
      trial    = '0;
      bit_idx  = 0;
      for (int l = 0; l < ipt_pkg::NumLanes; l++) begin
        for (int j = 0; j < BITS_PER_STAGE; j++) begin
          bit_idx = TopBit - j;
          if (bit_idx >= 0) begin
            trial = {rem_nxt[l], work_nxt[l][bit_idx[ipt_pkg::NumIdxW-1:0]]};
            if (trial >= {1'b0, period}) begin
              trial = trial - {1'b0, period};
              work_nxt[l][bit_idx[ipt_pkg::NumIdxW-1:0]] = 1'b1;
            end else begin
              work_nxt[l][bit_idx[ipt_pkg::NumIdxW-1:0]] = 1'b0;
            end
            rem_nxt[l] = trial[ipt_pkg::RemW-1:0];
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (stage_en[s]) begin
        work_r[s] <= work_nxt;
        rem_r[s]  <= rem_nxt;
        mode_r[s] <= mode_stage_in;
      end
    end
  end

  assign quo_out  = work_r[Stages-1];
  assign mode_out = mode_r[Stages-1];

endmodule

@@ design/ipt_pack.sv @@
// Last pipeline stage: turns the clock counts into the active-time code and
// the packed address/data setup byte, and holds the result. Depends on ipt_pkg.
module ipt_pack (
  input  logic                        clk,
  input  logic                        stage_en,
  input  logic [ipt_pkg::ChipW-1:0]   chip_version,
  input  ipt_pkg::lanes_t             quo_in,
  input  ipt_pkg::mode_t              mode_in,
  output ipt_pkg::mode_t              chosen_mode,
  output logic [ipt_pkg::CodeW-1:0]   active_code,
  output logic [ipt_pkg::CodeW-1:0]   setup_code
);

  localparam int ExtW = ipt_pkg::NumW + 1;

  ipt_pkg::mode_t            mode_r;
  logic [ipt_pkg::CodeW-1:0] active_r, active_nxt;
  logic [ipt_pkg::CodeW-1:0] setup_r, setup_nxt;

  // Active time code from the cycle count.
  always_comb begin
    logic [ipt_pkg::NumW-1:0] qc;
    qc = quo_in[ipt_pkg::LaneCycle];
    if (qc <= ipt_pkg::NumW'(2)) begin
      active_nxt = ipt_pkg::ActiveUpTo2;
    end else if (qc == ipt_pkg::NumW'(3)) begin
      active_nxt = ipt_pkg::Active3;
    end else if (qc == ipt_pkg::NumW'(4)) begin
      active_nxt = ipt_pkg::Active4;
    end else begin
      active_nxt = ipt_pkg::ActiveLong;
    end
  end

  // Address and data setup counts with their clamps.
  always_comb begin
    logic [ExtW-1:0] a_cnt;
    logic [ExtW-1:0] d_cnt;
    logic [ExtW-1:0] diff;
    logic [4:0]      b_cnt;
    logic [3:0]      a_nib;
    logic [3:0]      b_nib;

    a_cnt = ExtW'(quo_in[ipt_pkg::LaneAddr]);
    if (a_cnt < ExtW'(ipt_pkg::MinClocks)) begin
      a_cnt = ExtW'(ipt_pkg::MinClocks);
    end
    d_cnt = ExtW'(quo_in[ipt_pkg::LaneData]);
    diff  = d_cnt - a_cnt;

    if (diff[ExtW-1] || (diff < ExtW'(ipt_pkg::MinClocks))) begin
      b_cnt = 5'(ipt_pkg::MinClocks);
    end else if (diff > ExtW'(ipt_pkg::DataLimit)) begin
      // The excess moves into the address count.
      a_cnt = d_cnt - ExtW'(ipt_pkg::DataLimit);
      b_cnt = 5'(ipt_pkg::DataLimit);
    end else begin
      b_cnt = diff[4:0];
    end

    if (a_cnt > ExtW'(ipt_pkg::AddrLimit)) begin
      a_nib = '0;
    end else begin
      a_nib = a_cnt[3:0];
    end

    // Later controller revisions take one clock off the data count.
    if (chip_version > ipt_pkg::ChipW'(1)) begin
      b_cnt = b_cnt - 5'd1;
    end
    if (b_cnt > 5'(ipt_pkg::NibLimit)) begin
      b_nib = '0;
    end else begin
      b_nib = b_cnt[3:0];
    end

    setup_nxt = {a_nib, b_nib};
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (stage_en) begin
      mode_r   <= mode_in;
      active_r <= active_nxt;
      setup_r  <= setup_nxt;
    end
  end

  assign chosen_mode = mode_r;
  assign active_code = active_r;
  assign setup_code  = setup_r;

endmodule

@@ design/ide_pio_timing_calculator.sv @@
// IDE PIO timing calculator, top level: configuration registers, pipeline
// valid chain and the select, divider and pack stages. Depends on ipt_pkg.
// Each accepted item passes the select register, the divider stage registers
// and the pack result register before it shows on out_valid.
// Throughput: one item per cycle; the bubble-collapsing valid chain keeps
// accepting items while a result waits, until every stage holds one.
// Reset (synchronous, rst_n low): all stages empty, clock period 30, chip 1.
module ide_pio_timing_calculator #(
  parameter int BITS_PER_STAGE = ipt_pkg::DivBitsPerStage
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Configuration port
  input  logic                          cfg_write_en,
  input  logic [ipt_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [ipt_pkg::CfgDataW-1:0]  cfg_data,
  // Input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_known_valid,
  input  logic [ipt_pkg::ModeW-1:0]     in_known_mode,
  input  logic [ipt_pkg::BasicW-1:0]    in_basic_mode,
  input  logic                          in_extended_valid,
  input  logic                          in_iordy_capable,
  input  logic [ipt_pkg::AdvW-1:0]      in_advanced_modes,
  input  logic [ipt_pkg::TimeW-1:0]     in_iordy_cycle_ns,
  input  logic [ipt_pkg::TimeW-1:0]     in_plain_cycle_ns,
  // Result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ipt_pkg::ModeW-1:0]     out_chosen_mode,
  output logic [ipt_pkg::CodeW-1:0]     out_active_code,
  output logic [ipt_pkg::CodeW-1:0]     out_setup_code
);

  localparam int DivStages = (ipt_pkg::NumW + BITS_PER_STAGE - 1) / BITS_PER_STAGE;
  localparam int NumStg    = DivStages + 2;

  logic [ipt_pkg::PeriodW-1:0] period_r;
  logic [ipt_pkg::ChipW-1:0]   chip_r;
  logic [NumStg-1:0]           valid_r, valid_nxt;
  logic [NumStg-1:0]           stage_en;

  ipt_pkg::lanes_t num_s0, quo_div;
  ipt_pkg::mode_t  mode_s0, mode_div;

  // Configuration registers; a zero period is stored as one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= ipt_pkg::PeriodReset;
      chip_r   <= ipt_pkg::ChipReset;
    end else if (cfg_write_en) begin
      case (cfg_index)
        ipt_pkg::CfgClockPeriod: begin
          period_r <= (cfg_data == '0) ? ipt_pkg::PeriodW'(1) : cfg_data;
        end
        ipt_pkg::CfgChipVersion: begin
          chip_r <= cfg_data[ipt_pkg::ChipW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // A stage moves when it is empty or the stage after it moves.
  always_comb begin
    stage_en[NumStg-1] = !valid_r[NumStg-1] || !out_stall;
    for (int k = NumStg - 2; k >= 0; k--) begin
      stage_en[k] = !valid_r[k] || stage_en[k+1];
    end
    for (int k = 0; k < NumStg; k++) begin
      if (!stage_en[k]) begin
        valid_nxt[k] = valid_r[k];
      end else if (k == 0) begin
        valid_nxt[k] = in_valid;
      end else begin
        valid_nxt[k] = valid_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign in_stall  = !stage_en[0];
  assign out_valid = valid_r[NumStg-1];

  // Mode and timing selection.
  ipt_select u_select (
    .clk            (clk),
    .stage_en       (stage_en[0]),
    .period         (period_r),
    .known_valid    (in_known_valid),
    .known_mode     (in_known_mode),
    .basic_mode     (in_basic_mode),
    .extended_valid (in_extended_valid),
    .iordy_capable  (in_iordy_capable),
    .advanced_modes (in_advanced_modes),
    .iordy_cycle_ns (in_iordy_cycle_ns),
    .plain_cycle_ns (in_plain_cycle_ns),
    .num_out        (num_s0),
    .mode_out       (mode_s0)
  );

  // Ceiling divisions by the clock period.
  ipt_divider #(
    .BITS_PER_STAGE (BITS_PER_STAGE)
  ) u_divider (
    .clk      (clk),
    .stage_en (stage_en[DivStages:1]),
    .period   (period_r),
    .num_in   (num_s0),
    .mode_in  (mode_s0),
    .quo_out  (quo_div),
    .mode_out (mode_div)
  );

  // Code packing and result register.
  ipt_pack u_pack (
    .clk          (clk),
    .stage_en     (stage_en[NumStg-1]),
    .chip_version (chip_r),
    .quo_in       (quo_div),
    .mode_in      (mode_div),
    .chosen_mode  (out_chosen_mode),
    .active_code  (out_active_code),
    .setup_code   (out_setup_code)
  );

endmodule

@@ design/ipt_checker.sv @@
// Port-level checker for the IDE PIO timing calculator, bound to the top level.
// Depends on ipt_pkg and on the top level's port names.
module ipt_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [ipt_pkg::ModeW-1:0]   out_chosen_mode,
  input logic [ipt_pkg::CodeW-1:0]   out_active_code,
  input logic [ipt_pkg::CodeW-1:0]   out_setup_code
);

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // With no result waiting, the pipeline always has room for an item.
  a_room_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
      !out_valid |-> !in_stall)
    else $error("input stalled while the result register is empty");

  // A stalled input item stays offered until it is taken.
  a_input_holds: assert property (@(posedge clk) disable iff (!rst_n)
      in_valid && in_stall |=> in_valid)
    else $error("stalled input item withdrawn");

  // A stalled result holds.
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && out_stall |=> out_valid && $stable(out_chosen_mode)
      && $stable(out_active_code) && $stable(out_setup_code))
    else $error("stalled result changed");

  // Results carry a legal mode and one of the four active codes.
  a_result_codes: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid |-> (out_chosen_mode <= ipt_pkg::MaxMode)
      && (out_active_code[5:0] == 6'd0))
    else $error("illegal mode or active code in result");

endmodule

bind ide_pio_timing_calculator ipt_checker u_ipt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_chosen_mode (out_chosen_mode),
  .out_active_code (out_active_code),
  .out_setup_code  (out_setup_code)
);
